// File: hw/rtl/mis_pkg.sv
// Shared types and constants for the maximum independent set search block.
// Used by mis_ctrl, mis_datapath and max_independent_set_search.
`default_nettype none

package mis_pkg;

  localparam int unsigned MAX_VERTICES = 16;

  localparam int unsigned VCOUNT_W = 5;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SIZE_W   = 5;
  localparam int unsigned SET_W    = 16;

  localparam logic [KIND_W-1:0] KIND_EDGE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PROPOSE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH  = 2'd2;

  localparam logic RES_VERDICT = 1'b0;
  localparam logic RES_SEARCH  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_POST   = 3'b100
  } state_t;

  typedef struct packed {
    logic do_edge;
    logic do_propose;
    logic search_start;
    logic search_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/mis_ctrl.sv
// Controller for the independent set block: accepts beats, sequences the search,
// posts results. Depends on mis_pkg.
`default_nettype none

module mis_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [mis_pkg::KIND_W-1:0]  kind,
  input  wire logic                        last,
  input  wire mis_pkg::status_t            status,
  output mis_pkg::cmd_t                    cmd
);

  mis_pkg::state_t state, state_next;
  logic            accept;

  assign s_tready = (state == mis_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      mis_pkg::ST_IDLE: begin
        if (accept) begin
          case (kind)
            mis_pkg::KIND_EDGE: begin
              cmd.do_edge = 1'b1;
            end
            mis_pkg::KIND_PROPOSE: begin
              cmd.do_propose = 1'b1;
              if (last) begin
                state_next = mis_pkg::ST_POST;
              end
            end
            mis_pkg::KIND_SEARCH: begin
              cmd.search_start = 1'b1;
              state_next       = mis_pkg::ST_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end
      mis_pkg::ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_done) begin
          state_next = mis_pkg::ST_POST;
        end
      end
      mis_pkg::ST_POST: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = mis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mis_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mis_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mis_datapath.sv
// Datapath: adjacency matrix, proposal tracking, depth-first search walker and
// output register. Depends on mis_pkg; driven by mis_ctrl commands.
`default_nettype none

module mis_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [mis_pkg::VCOUNT_W-1:0]  cfg_data,
  input  wire logic [mis_pkg::ID_W-1:0]      vertex_a,
  input  wire logic [mis_pkg::ID_W-1:0]      vertex_b,
  input  wire logic                          last,
  input  wire mis_pkg::cmd_t                 cmd,
  output mis_pkg::status_t                   status,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_kind,
  output logic                               out_indep,
  output logic [mis_pkg::SIZE_W-1:0]         out_size,
  output logic [mis_pkg::SET_W-1:0]          out_set
);

  localparam int unsigned MAX_VERTICES = mis_pkg::MAX_VERTICES;
  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  logic [MAX_VERTICES-1:0]        adj [MAX_VERTICES];
  logic [mis_pkg::VCOUNT_W-1:0]   vertex_count;
  logic [mis_pkg::VCOUNT_W-1:0]   n_active;

  logic [MAX_VERTICES-1:0]        prop_mask;
  logic                           prop_bad;

  logic [MAX_VERTICES-1:0]        cur_set;
  logic [mis_pkg::SIZE_W-1:0]     depth;
  logic [CW-1:0]                  cursor;
  logic [mis_pkg::SIZE_W-1:0]     best_size;
  logic [MAX_VERTICES-1:0]        best_set;
  logic                           res_kind;
  logic                           res_indep;

  logic [VW-1:0]                  a_idx, b_idx, rd_idx, top_idx;
  logic                           a_ok, b_ok, cursor_lt_n;
  logic [MAX_VERTICES-1:0]        row, a_bit, cur_bit, top_bit;
  logic                           bad_new;

  assign n_active = (vertex_count > mis_pkg::VCOUNT_W'(MAX_VERTICES)) ?
                    mis_pkg::VCOUNT_W'(MAX_VERTICES) : vertex_count;

  assign a_idx = VW'(vertex_a);
  assign b_idx = VW'(vertex_b);
  assign a_ok  = mis_pkg::VCOUNT_W'(vertex_a) < n_active;
  assign b_ok  = mis_pkg::VCOUNT_W'(vertex_b) < n_active;

  assign cursor_lt_n = mis_pkg::VCOUNT_W'(cursor) < n_active;

  // single row read port
  assign rd_idx = cmd.search_step ? cursor[VW-1:0] : a_idx;
  assign row    = adj[rd_idx];

  assign a_bit   = MAX_VERTICES'(1) << a_idx;
  assign cur_bit = MAX_VERTICES'(1) << cursor[VW-1:0];
  assign top_bit = MAX_VERTICES'(1) << top_idx;

  assign bad_new = prop_bad || !a_ok || ((row & prop_mask) != '0);

  // highest vertex in the current set: the one chosen last
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (cur_set[i]) begin
        top_idx = VW'(i);
      end
    end
  end

  assign status.search_done = !cursor_lt_n && (cur_set == '0);
  assign status.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj[i] <= '0;
      end
    end else if (cmd.do_edge && a_ok && b_ok) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (VW'(i) == a_idx) begin
          adj[i][b_idx] <= 1'b1;
        end
        if (VW'(i) == b_idx) begin
          adj[i][a_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_mask <= '0;
      prop_bad  <= 1'b0;
    end else if (cmd.do_propose) begin
      if (last) begin
        prop_mask <= '0;
        prop_bad  <= 1'b0;
      end else begin
        prop_mask <= a_ok ? (prop_mask | a_bit) : prop_mask;
        prop_bad  <= bad_new;
      end
    end
  end

  // result staging and search walker
  always_ff @(posedge clk) begin
    if (cmd.do_propose && last) begin
      res_kind  <= mis_pkg::RES_VERDICT;
      res_indep <= !bad_new;
      best_size <= '0;
      best_set  <= '0;
    end else if (cmd.search_start) begin
      res_kind  <= mis_pkg::RES_SEARCH;
      res_indep <= 1'b0;
      best_size <= '0;
      best_set  <= '0;
      cur_set   <= '0;
      depth     <= '0;
      cursor    <= '0;
    end else if (cmd.search_step) begin
      if (cursor_lt_n) begin
        if ((row & cur_set) == '0) begin
          cur_set <= cur_set | cur_bit;
          depth   <= depth + 1'b1;
          if ((depth != '0) && ((depth + 1'b1) > best_size)) begin
            best_size <= depth + 1'b1;
            best_set  <= cur_set | cur_bit;
          end
        end
        cursor <= cursor + 1'b1;
      end else if (cur_set != '0) begin
        cur_set <= cur_set & ~top_bit;
        depth   <= depth - 1'b1;
        cursor  <= CW'(top_idx) + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind  <= res_kind;
      out_indep <= res_indep;
      out_size  <= best_size;
      out_set   <= mis_pkg::SET_W'(best_set);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/max_independent_set_search.sv
// Channel  | Signals                          | Beat content
// cfg      | cfg_valid cfg_ready cfg_data     | vertex_count
// s (in)   | s_tvalid s_tready s_tdata s_tuser s_tlast | edge, proposal vertex, search
// m (out)  | m_tvalid m_tready m_tdata m_tuser | verdict or search result
//
// Edge, unused-kind and non-last proposal beats are handled as they are accepted; a last
// proposal beat is accepted, then its verdict is posted. Search: the beat is accepted,
// then the depth-first walk tests one candidate or backtracks per step until it sees
// the walk end, then the result is posted.
// Reset clears the adjacency matrix, proposal state and vertex_count at once.
// s_tready is low while searching and in the post state, which lasts until the
// output register is free.
// Top level; depends on mis_pkg, mis_ctrl and mis_datapath.
`default_nettype none

module max_independent_set_search (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mis_pkg::VCOUNT_W-1:0]  cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,  // vertex_a[3:0], vertex_b[7:4]
  input  wire logic [mis_pkg::KIND_W-1:0]    s_tuser,  // kind
  input  wire logic                          s_tlast,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [23:0]                        m_tdata,  // independent[0], best_size[5:1],
                                                       // best_set[21:6], zero[23:22]
  output logic [0:0]                         m_tuser   // result_kind
);

  mis_pkg::cmd_t              cmd;
  mis_pkg::status_t           status;
  logic                       out_kind;
  logic                       out_indep;
  logic [mis_pkg::SIZE_W-1:0] out_size;
  logic [mis_pkg::SET_W-1:0]  out_set;

  assign cfg_ready = 1'b1;

  mis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (s_tuser),
    .last     (s_tlast),
    .status   (status),
    .cmd      (cmd)
  );

  mis_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .vertex_a  (s_tdata[3:0]),
    .vertex_b  (s_tdata[7:4]),
    .last      (s_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_kind  (out_kind),
    .out_indep (out_indep),
    .out_size  (out_size),
    .out_set   (out_set)
  );

  assign m_tdata = {2'b00, out_set, out_size, out_indep};
  assign m_tuser = out_kind;

endmodule

`default_nettype wire

// File: tb/max_independent_set_search_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for max_independent_set_search: graph edges, proposal verdicts
// and exhaustive searches, checked against a graph model kept in a scoreboard class.
// Depends on mis_pkg and the max_independent_set_search RTL.

module max_independent_set_search_tb;

  localparam logic [mis_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned SEARCH_BUDGET = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BEATS = 90;
  localparam int unsigned NUM_PHASES = 14;

  class mis_scoreboard;
    typedef struct packed {
      logic                       result_kind;
      logic                       independent;
      logic [mis_pkg::SIZE_W-1:0] best_size;
      logic [mis_pkg::SET_W-1:0]  best_set;
    } outcome_t;

    logic [mis_pkg::SET_W-1:0]    adj [16];
    logic [mis_pkg::SET_W-1:0]    prop_mask;
    logic                         prop_bad;
    logic [mis_pkg::VCOUNT_W-1:0] vcount;
    outcome_t                     expected_q [$];
    int                           errors;
    int unsigned                  found_size;
    int unsigned                  walk_nodes;
    logic [mis_pkg::SET_W-1:0]    found_set;

    function new();
      foreach (adj[i]) adj[i] = '0;
      prop_mask = '0;
      prop_bad = 1'b0;
      vcount = '0;
      errors = 0;
    endfunction

    function int unsigned active();
      return (vcount > 16) ? 16 : 32'(vcount);
    endfunction

    // depth-first walk over independent sets; first strictly larger set wins
    function void explore(int unsigned n, int unsigned depth, int unsigned first,
                          logic [mis_pkg::SET_W-1:0] members);
      walk_nodes++;
      if (depth > 1 && depth > found_size) begin
        found_size = depth;
        found_set = members;
      end
      if (depth >= n) return;
      for (int unsigned v = first; v < n; v++) begin
        if ((adj[v] & members) == '0) explore(n, depth + 1, v + 1, members | (16'd1 << v));
      end
    endfunction

    function void run_search();
      found_size = 0;
      found_set = '0;
      walk_nodes = 0;
      explore(active(), 0, 0, '0);
    endfunction

    function void note_input(logic [mis_pkg::KIND_W-1:0] kind, logic [mis_pkg::ID_W-1:0] a,
                             logic [mis_pkg::ID_W-1:0] b, logic last);
      int unsigned n;
      outcome_t o;
      n = active();
      o = '0;
      case (kind)
        mis_pkg::KIND_EDGE: begin
          if (a < n && b < n) begin
            adj[a][b] = 1'b1;
            adj[b][a] = 1'b1;
          end
        end
        mis_pkg::KIND_PROPOSE: begin
          if (a < n) begin
            if ((adj[a] & prop_mask) != '0) prop_bad = 1'b1;
            prop_mask[a] = 1'b1;
          end else begin
            prop_bad = 1'b1;
          end
          if (last) begin
            o.result_kind = mis_pkg::RES_VERDICT;
            o.independent = !prop_bad;
            expected_q.push_back(o);
            prop_mask = '0;
            prop_bad = 1'b0;
          end
        end
        mis_pkg::KIND_SEARCH: begin
          run_search();
          o.result_kind = mis_pkg::RES_SEARCH;
          o.best_size = mis_pkg::SIZE_W'(found_size);
          o.best_set = found_set;
          expected_q.push_back(o);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [0:0] kind, logic [23:0] data);
      outcome_t o;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind %0d data 0x%h",
                 $time, kind, data);
      end else begin
        o = expected_q.pop_front();
        compare_field("result_kind", 32'(o.result_kind), 32'(kind));
        compare_field("independent", 32'(o.independent), 32'(data[0]));
        compare_field("best_size", 32'(o.best_size), 32'(data[5:1]));
        compare_field("best_set", 32'(o.best_set), 32'(data[21:6]));
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [mis_pkg::VCOUNT_W-1:0] cfg_data;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [7:0]                   s_tdata;   // vertex_a[3:0], vertex_b[7:4]
  logic [mis_pkg::KIND_W-1:0]   s_tuser;   // kind
  logic                         s_tlast;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [23:0]                  m_tdata;   // independent[0], best_size[5:1], best_set[21:6]
  logic [0:0]                   m_tuser;   // result_kind

  mis_scoreboard sb = new();
  bit            hold_req = 1'b0;
  bit            s_steady = 1'b0;
  bit            m_steady = 1'b0;
  int unsigned   beats_sent = 0;

  max_independent_set_search u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [mis_pkg::ID_W-1:0] rand_id();
    return mis_pkg::ID_W'($urandom_range(15));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  task automatic send_beat(logic [mis_pkg::KIND_W-1:0] kind, logic [mis_pkg::ID_W-1:0] a,
                           logic [mis_pkg::ID_W-1:0] b, logic last);
    if (!s_steady && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {b, a};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_input(kind, a, b, last);
    if (kind != KIND_UNUSED) beats_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [mis_pkg::VCOUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.vcount = value;
  endtask

  function automatic logic [mis_pkg::ID_W-1:0] pick_id(int unsigned n);
    if (n > 0 && $urandom_range(9) != 0) return mis_pkg::ID_W'($urandom_range(n - 1));
    return rand_id();
  endfunction

  // half the proposals are grown greedily to stay independent
  task automatic send_proposal();
    int unsigned               n;
    int unsigned               len;
    bit                        greedy;
    logic [mis_pkg::SET_W-1:0] chosen;
    n = sb.active();
    len = $urandom_range(1, 5);
    greedy = rand_bit();
    chosen = '0;
    for (int i = 0; i < len; i++) begin
      logic [mis_pkg::ID_W-1:0] id;
      id = pick_id(n);
      if (greedy && n > 0) begin
        for (int t = 0; t < 8 && (id >= n || (sb.adj[id] & chosen) != '0); t++)
          id = mis_pkg::ID_W'($urandom_range(n - 1));
      end
      chosen[id] = 1'b1;
      send_beat(mis_pkg::KIND_PROPOSE, id, rand_id(), i == len - 1);
      if (i < len - 1 && $urandom_range(9) == 0)
        send_beat(mis_pkg::KIND_EDGE, pick_id(n), pick_id(n), rand_bit());
    end
  endtask

  task automatic send_random_item(int unsigned edge_pct);
    int unsigned n;
    int unsigned r;
    n = sb.active();
    r = $urandom_range(99);
    if (r < edge_pct) begin
      send_beat(mis_pkg::KIND_EDGE, pick_id(n), pick_id(n), rand_bit());
    end else if (r < edge_pct + 10) begin
      // searches on sparse large graphs take too long; densify instead
      sb.run_search();
      if (sb.walk_nodes * (n + 1) <= SEARCH_BUDGET)
        send_beat(mis_pkg::KIND_SEARCH, rand_id(), rand_id(), rand_bit());
      else
        send_beat(mis_pkg::KIND_EDGE, pick_id(n), pick_id(n), 1'b0);
    end else if (r < edge_pct + 13) begin
      send_beat(KIND_UNUSED, rand_id(), rand_id(), rand_bit());
    end else begin
      send_proposal();
    end
  endtask

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= m_steady || ($urandom_range(99) >= 28);
      end
    end
  end

  initial begin
    #(100_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned phase_vc [NUM_PHASES];
    int unsigned start;
    bit          paused;
    phase_vc = '{5, 8, 0, 3, 10, 16, 31, 12, 2, 16, 7, 20, 1, 16};
    paused = 1'b0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= mis_pkg::KIND_EDGE;
    s_tlast <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // no vertices in use after reset
    send_beat(mis_pkg::KIND_SEARCH, 4'd0, 4'd0, 1'b0);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd0, 4'd0, 1'b1);
    send_beat(mis_pkg::KIND_EDGE, 4'd0, 4'd1, 1'b0);
    drain();
    write_vertex_count(5'd1);
    send_beat(mis_pkg::KIND_SEARCH, 4'd15, 4'd15, 1'b1);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd0, 4'd15, 1'b1);
    send_beat(mis_pkg::KIND_EDGE, 4'd0, 4'd0, 1'b0);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd0, 4'd0, 1'b0);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd0, 4'd0, 1'b1);
    send_beat(mis_pkg::KIND_EDGE, 4'd0, 4'd1, 1'b0);
    drain();
    write_vertex_count(5'd4);
    send_beat(mis_pkg::KIND_EDGE, 4'd0, 4'd1, 1'b0);
    send_beat(mis_pkg::KIND_EDGE, 4'd2, 4'd3, 1'b0);
    send_beat(mis_pkg::KIND_EDGE, 4'd15, 4'd15, 1'b1);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd1, 4'd0, 1'b0);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd2, 4'd0, 1'b1);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd0, 4'd0, 1'b0);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd1, 4'd0, 1'b1);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd2, 4'd0, 1'b0);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd2, 4'd0, 1'b1);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd2, 4'd0, 1'b0);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd15, 4'd0, 1'b1);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd1, 4'd0, 1'b0);
    send_beat(mis_pkg::KIND_EDGE, 4'd1, 4'd2, 1'b0);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd2, 4'd0, 1'b1);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd0, 4'd0, 1'b0);
    send_beat(mis_pkg::KIND_SEARCH, 4'd0, 4'd0, 1'b0);
    send_beat(mis_pkg::KIND_PROPOSE, 4'd3, 4'd0, 1'b1);
    send_beat(KIND_UNUSED, 4'd15, 4'd15, 1'b1);
    send_beat(mis_pkg::KIND_SEARCH, 4'd0, 4'd0, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_vertex_count(mis_pkg::VCOUNT_W'(phase_vc[p]));
      if (p == 2) hold_req = 1'b1;
      s_steady = (p == 4);
      m_steady = (p == 4);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        if (p == 7 && !paused && beats_sent - start >= PHASE_BEATS / 2) begin
          drain();
          paused = 1'b1;
        end
        send_random_item(phase_vc[p] >= 12 ? 35 : 12);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
